// ----- hdl/skvl_pkg.sv -----
// ---------------------------------------------------------------------------
// skvl_pkg
// Shared types and constants of the sorted key/value list.
// ---------------------------------------------------------------------------
package skvl_pkg;

    localparam int CAPACITY      = 16;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W         = 8;
    localparam int VALUE_W       = 32;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Request types
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Broadcast command to every cell
    typedef struct packed {
        logic                      ins;   // insert at the first slot not below key
        logic                      rem;   // close the gap at the first match
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

    // Compare flags that each cell hands to its neighbor
    typedef struct packed {
        logic ge;     // empty slot, or held key not below the query
        logic eq;     // occupied and key equals the query
    } t_cell_flags;

endpackage

// ----- hdl/skvl_req_if.sv -----
// ---------------------------------------------------------------------------
// skvl_req_if
// Request channel: valid/ready handshake with request type, key and value.
// ---------------------------------------------------------------------------
interface skvl_req_if;
    logic                                        valid;
    logic                                        ready;
    logic        [skvl_pkg::REQ_W-1:0]           req_type;
    logic signed [skvl_pkg::KEY_W-1:0]           key;
    logic signed [skvl_pkg::VALUE_W-1:0]         value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

// ----- hdl/skvl_rsp_if.sv -----
// ---------------------------------------------------------------------------
// skvl_rsp_if
// Result channel: valid/ready handshake with status, entry and count.
// ---------------------------------------------------------------------------
interface skvl_rsp_if;
    logic                                        valid;
    logic                                        ready;
    logic        [skvl_pkg::STATUS_W-1:0]        status;
    logic signed [skvl_pkg::KEY_W-1:0]           out_key;
    logic signed [skvl_pkg::VALUE_W-1:0]         out_value;
    logic        [skvl_pkg::ENTRY_COUNT_W-1:0]   entry_count;

    modport source (output valid, status, out_key, out_value, entry_count, input ready);
    modport sink   (input valid, status, out_key, out_value, entry_count, output ready);
endinterface

// ----- hdl/skvl_cell.sv -----
// ---------------------------------------------------------------------------
// skvl_cell
// One slot of the list: holds a key/value pair, compares it with the query
// and shifts up or down with its neighbors.
// ---------------------------------------------------------------------------
module skvl_cell (
    input  logic                                i_clk,
    input  skvl_pkg::t_cell_cmd                 i_cmd,
    input  logic                                i_occupied,
    input  skvl_pkg::t_cell_flags               i_prev_flags,
    input  logic signed [skvl_pkg::KEY_W-1:0]   i_prev_key,
    input  logic signed [skvl_pkg::VALUE_W-1:0] i_prev_value,
    input  logic signed [skvl_pkg::KEY_W-1:0]   i_next_key,
    input  logic signed [skvl_pkg::VALUE_W-1:0] i_next_value,
    output skvl_pkg::t_cell_flags               o_flags,
    output logic                                o_first,
    output logic signed [skvl_pkg::KEY_W-1:0]   o_key,
    output logic signed [skvl_pkg::VALUE_W-1:0] o_value
);

    logic signed [skvl_pkg::KEY_W-1:0]   r_key;
    logic signed [skvl_pkg::VALUE_W-1:0] r_value;
    logic signed [skvl_pkg::KEY_W-1:0]   n_key;
    logic signed [skvl_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        o_flags.ge = !i_occupied || (r_key >= i_cmd.key);
        o_flags.eq = i_occupied && (r_key == i_cmd.key);
        o_first    = o_flags.eq && !i_prev_flags.eq;
    end

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.ins && o_flags.ge) begin
            // first slot not below the key takes the new entry, later ones move up
            if (!i_prev_flags.ge) begin
                n_key   = i_cmd.key;
                n_value = i_cmd.value;
            end else begin
                n_key   = i_prev_key;
                n_value = i_prev_value;
            end
        end else if (i_cmd.rem && o_flags.ge) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ----- hdl/sorted_key_value_list.sv -----
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in parallel.
// A request is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) empties the list and the result register;
// entry storage is not cleared, slots at or above the fill count are ignored.
// ---------------------------------------------------------------------------
// sorted_key_value_list
// Fixed-capacity list of signed-key/value entries kept in ascending key order
// by a row of compare-and-shift cells; insert, remove and search.
// ---------------------------------------------------------------------------
module sorted_key_value_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skvl_req_if.sink    i_req,
    skvl_rsp_if.source  o_rsp
);

    // Fill count and result register
    logic [skvl_pkg::COUNT_W-1:0]        r_count;
    logic [skvl_pkg::COUNT_W-1:0]        n_count;
    logic                                r_out_valid;
    logic [skvl_pkg::STATUS_W-1:0]       r_status;
    logic signed [skvl_pkg::KEY_W-1:0]   r_out_key;
    logic signed [skvl_pkg::VALUE_W-1:0] r_out_value;
    logic [skvl_pkg::STATUS_W-1:0]       n_status;
    logic signed [skvl_pkg::KEY_W-1:0]   n_out_key;
    logic signed [skvl_pkg::VALUE_W-1:0] n_out_value;

    // Chain wiring
    skvl_pkg::t_cell_cmd                 w_cmd;
    skvl_pkg::t_cell_flags               w_flags [skvl_pkg::CAPACITY];
    logic [skvl_pkg::CAPACITY-1:0]       w_first;
    logic signed [skvl_pkg::KEY_W-1:0]   w_key   [skvl_pkg::CAPACITY];
    logic signed [skvl_pkg::VALUE_W-1:0] w_value [skvl_pkg::CAPACITY];

    logic                                accept;
    logic                                full;
    logic                                hit;
    logic signed [skvl_pkg::KEY_W-1:0]   found_key;
    logic signed [skvl_pkg::VALUE_W-1:0] found_value;

    // Take a new item while the result slot is free or being taken
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == skvl_pkg::COUNT_W'(skvl_pkg::CAPACITY));
    assign hit         = |w_first;

    always_comb begin
        w_cmd.key   = i_req.key;
        w_cmd.value = i_req.value;
        w_cmd.ins   = accept && (i_req.req_type == skvl_pkg::REQ_INSERT) && !full;
        w_cmd.rem   = accept && (i_req.req_type == skvl_pkg::REQ_REMOVE) && hit;
    end

    // Row of cells; each sees its left and right neighbor
    for (genvar i = 0; i < skvl_pkg::CAPACITY; i++) begin : g_cell
        skvl_pkg::t_cell_flags               prev_flags;
        logic signed [skvl_pkg::KEY_W-1:0]   prev_key;
        logic signed [skvl_pkg::VALUE_W-1:0] prev_value;
        logic signed [skvl_pkg::KEY_W-1:0]   next_key;
        logic signed [skvl_pkg::VALUE_W-1:0] next_value;

        if (i == 0) begin : g_head
            assign prev_flags = '0;
            assign prev_key   = i_req.key;
            assign prev_value = i_req.value;
        end else begin : g_body
            assign prev_flags = w_flags[i-1];
            assign prev_key   = w_key[i-1];
            assign prev_value = w_value[i-1];
        end

        if (i == skvl_pkg::CAPACITY - 1) begin : g_tail
            assign next_key   = w_key[i];
            assign next_value = w_value[i];
        end else begin : g_inner
            assign next_key   = w_key[i+1];
            assign next_value = w_value[i+1];
        end

        skvl_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_occupied   (skvl_pkg::COUNT_W'(i) < r_count),
            .i_prev_flags (prev_flags),
            .i_prev_key   (prev_key),
            .i_prev_value (prev_value),
            .i_next_key   (next_key),
            .i_next_value (next_value),
            .o_flags      (w_flags[i]),
            .o_first      (w_first[i]),
            .o_key        (w_key[i]),
            .o_value      (w_value[i])
        );
    end

    // Read out the first matching entry; at most one cell is selected
    always_comb begin
        found_key   = '0;
        found_value = '0;
        for (int j = 0; j < skvl_pkg::CAPACITY; j++) begin
            found_key   = found_key   | (w_key[j]   & {skvl_pkg::KEY_W{w_first[j]}});
            found_value = found_value | (w_value[j] & {skvl_pkg::VALUE_W{w_first[j]}});
        end
    end

    // Result and next count
    always_comb begin
        n_count     = r_count;
        n_status    = skvl_pkg::ST_DONE;
        n_out_key   = '0;
        n_out_value = '0;
        unique case (i_req.req_type)
            skvl_pkg::REQ_INSERT: begin
                n_out_key   = i_req.key;
                n_out_value = i_req.value;
                if (full) begin
                    n_status = skvl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            skvl_pkg::REQ_REMOVE: begin
                if (hit) begin
                    n_out_key   = found_key;
                    n_out_value = found_value;
                    n_count     = r_count - 1'b1;
                end else begin
                    n_status  = skvl_pkg::ST_MISS;
                    n_out_key = i_req.key;
                end
            end
            skvl_pkg::REQ_SEARCH: begin
                if (hit) begin
                    n_out_key   = found_key;
                    n_out_value = found_value;
                end else begin
                    n_status    = skvl_pkg::ST_MISS;
                    n_out_key   = i_req.key;
                    n_out_value = i_req.value;
                end
            end
            default: begin
                // unused request type: leave the list alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the result register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_key   <= n_out_key;
            r_out_value <= n_out_value;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_key     = r_out_key;
    assign o_rsp.out_value   = r_out_value;
    assign o_rsp.entry_count = skvl_pkg::ENTRY_COUNT_W'(r_count);

endmodule
